[rtl/core/dcpfb_pkg.sv]
// Types and constants shared by the potentiometer frame builder.
`timescale 1ns / 1ps

package dcpfb_pkg;

    localparam int WIPER_W      = 8;
    localparam int CHAN_W       = 3;
    localparam int CHANS        = 4;
    localparam int CHIP_BITS    = 11;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int BIT_POS_W    = 7;
    localparam int DIV11_MUL    = 187;
    localparam int DIV11_SHIFT  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd1;

    typedef struct packed {
        logic       func;
        logic [7:0] chip_index;
        logic [7:0] channel;
        logic [7:0] wiper_value;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
        logic       frame_valid;
        logic [7:0] frame_byte;
        logic       last;
    } res_t;

endpackage

[rtl/core/daisy_chain_pot_frame_builder.sv]
// Top level: request checking, shadow update and bit-serial frame builder.
`timescale 1ns / 1ps

// Frame builder for a daisy chain of 4-channel potentiometer chips. A request
// is taken only while the block is idle. Errors, reads and writes with a zero
// frame length give a single result. Other writes build the frame bit by bit:
// while a byte is gathered, each frame bit is fetched one per cycle through
// the single read port of the shadow memory, then a drain step lets the last
// read land and an emit step outputs the byte. A stalled result holds the
// sequencer in its emit step or its single-result step. The shadow needs no
// clearing pass after reset.

module daisy_chain_pot_frame_builder #(
    parameter int MAX_CHIPS       = 8,
    parameter int MAX_FRAME_BYTES = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  dcpfb_pkg::req_t                     req,
    output logic                                res_valid,
    input  logic                                res_stall,
    output dcpfb_pkg::res_t                     res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcpfb_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DEPTH  = MAX_CHIPS * dcpfb_pkg::CHANS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDWAIT,
        ST_ONE,
        ST_BITS,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    logic [dcpfb_pkg::CFG_W-1:0]      chip_count_reg, chip_count_next;
    logic [dcpfb_pkg::CFG_W-1:0]      frame_bytes_reg, frame_bytes_next;
    logic [3:0]                       k_reg, k_next;
    logic [3:0]                       r_reg, r_next;
    logic [2:0]                       bit_cnt_reg, bit_cnt_next;
    logic [3:0]                       byte_cnt_reg, byte_cnt_next;
    logic                             pipe_vld_reg, pipe_vld_next;
    logic                             pipe_inr_reg, pipe_inr_next;
    logic [3:0]                       pipe_r_reg, pipe_r_next;
    logic [7:0]                       acc_reg, acc_next;
    logic                             pend_status_reg, pend_status_next;
    logic [7:0]                       pend_rd_reg, pend_rd_next;
    logic                             out_valid_reg, out_valid_next;
    dcpfb_pkg::res_t                  out_reg, out_next;
    dcpfb_pkg::req_t                  req_reg;

    logic [3:0]                       chips_eff;
    logic [3:0]                       nb_eff;
    logic                             arg_err;
    logic                             out_free;
    logic                             inr;
    logic [dcpfb_pkg::BIT_POS_W-1:0]  p_top;
    logic [14:0]                      p_prod;
    logic [3:0]                       k_init;
    logic [3:0]                       r_init;
    logic [dcpfb_pkg::CHIP_BITS-1:0]  word;
    logic                             bit_in;
    logic                             wr_en;
    logic [ADDR_W-1:0]                req_addr;
    logic [ADDR_W-1:0]                rd_addr;
    logic [dcpfb_pkg::WIPER_W-1:0]    rd_data;

    assign chips_eff = (32'(chip_count_reg) > MAX_CHIPS) ? 4'(MAX_CHIPS) : chip_count_reg;
    assign nb_eff    = (32'(frame_bytes_reg) > MAX_FRAME_BYTES)
                       ? 4'(MAX_FRAME_BYTES) : frame_bytes_reg;
    assign arg_err   = (req_reg.chip_index >= 8'(chips_eff))
                       || (req_reg.channel >= 8'(dcpfb_pkg::CHANS));

    assign p_top  = 7'(8'({nb_eff, 3'b000}) - 8'd1);
    assign p_prod = 15'(p_top) * 15'(dcpfb_pkg::DIV11_MUL);
    assign k_init = 4'(p_prod >> dcpfb_pkg::DIV11_SHIFT);
    assign r_init = 4'(p_top - 7'(k_init) * 7'(dcpfb_pkg::CHIP_BITS));

    assign inr      = (k_reg < chips_eff);
    assign req_addr = ADDR_W'({req_reg.chip_index, req_reg.channel[1:0]});
    assign wr_en    = (state_reg == ST_CHECK) && !arg_err && !req_reg.func;
    assign rd_addr  = (state_reg == ST_BITS)
                      ? (inr ? ADDR_W'({k_reg, req_reg.channel[1:0]}) : '0)
                      : (arg_err ? '0 : req_addr);

    assign word   = {req_reg.channel[dcpfb_pkg::CHAN_W-1:0], rd_data};
    assign bit_in = pipe_inr_reg ? word[pipe_r_reg] : 1'b0;

    assign out_free  = !out_valid_reg || !res_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cfg_ready = 1'b1;

    dcpfb_shadow #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_shadow (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (req_addr),
        .wr_data (req_reg.wiper_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        chip_count_next  = chip_count_reg;
        frame_bytes_next = frame_bytes_reg;
        k_next           = k_reg;
        r_next           = r_reg;
        bit_cnt_next     = bit_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_inr_next    = inr;
        pipe_r_next      = r_reg;
        acc_next         = acc_reg;
        pend_status_next = pend_status_reg;
        pend_rd_next     = pend_rd_reg;
        out_valid_next   = out_valid_reg && res_stall;
        out_next         = out_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                dcpfb_pkg::CFG_CHIP_COUNT:  chip_count_next  = cfg_data;
                dcpfb_pkg::CFG_FRAME_BYTES: frame_bytes_next = cfg_data;
                default: ;
            endcase
        end

        if (pipe_vld_reg)
        begin
            acc_next = {acc_reg[6:0], bit_in};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                pend_rd_next = '0;
                if (arg_err)
                begin
                    pend_status_next = 1'b1;
                    state_next       = ST_ONE;
                end
                else if (req_reg.func)
                begin
                    pend_status_next = 1'b0;
                    state_next       = ST_RDWAIT;
                end
                else if (nb_eff == 4'd0)
                begin
                    pend_status_next = 1'b0;
                    state_next       = ST_ONE;
                end
                else
                begin
                    k_next        = k_init;
                    r_next        = r_init;
                    bit_cnt_next  = '0;
                    byte_cnt_next = nb_eff;
                    state_next    = ST_BITS;
                end
            end
            ST_RDWAIT:
            begin
                pend_rd_next = rd_data;
                state_next   = ST_ONE;
            end
            ST_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = pend_status_reg;
                    out_next.read_data    = pend_rd_reg;
                    out_next.frame_valid  = 1'b0;
                    out_next.frame_byte   = '0;
                    out_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_BITS:
            begin
                pipe_vld_next = 1'b1;
                if (r_reg == 4'd0)
                begin
                    r_next = 4'(dcpfb_pkg::CHIP_BITS - 1);
                    k_next = k_reg - 4'd1;
                end
                else
                begin
                    r_next = r_reg - 4'd1;
                end
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = 1'b0;
                    out_next.read_data    = '0;
                    out_next.frame_valid  = 1'b1;
                    out_next.frame_byte   = acc_reg;
                    out_next.last         = (byte_cnt_reg == 4'd1);
                    byte_cnt_next         = byte_cnt_reg - 4'd1;
                    state_next            = (byte_cnt_reg == 4'd1) ? ST_IDLE : ST_BITS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chip_count_reg  <= 4'd1;
            frame_bytes_reg <= 4'd2;
            bit_cnt_reg     <= '0;
            byte_cnt_reg    <= '0;
            pipe_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            chip_count_reg  <= chip_count_next;
            frame_bytes_reg <= frame_bytes_next;
            bit_cnt_reg     <= bit_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
            pipe_vld_reg    <= pipe_vld_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            req_reg <= req;
        end
        k_reg           <= k_next;
        r_reg           <= r_next;
        pipe_inr_reg    <= pipe_inr_next;
        pipe_r_reg      <= pipe_r_next;
        acc_reg         <= acc_next;
        pend_status_reg <= pend_status_next;
        pend_rd_reg     <= pend_rd_next;
    end

endmodule

[rtl/core/dcpfb_shadow.sv]
// Wiper shadow memory with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps

module dcpfb_shadow #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [dcpfb_pkg::WIPER_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [dcpfb_pkg::WIPER_W-1:0] rd_data
);

    logic [dcpfb_pkg::WIPER_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]              valid_reg;
    logic [dcpfb_pkg::WIPER_W-1:0] data_reg;
    logic                          hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule
